>>> hw/rtl/tkcs_pkg.sv
// ---------------------------------------------------------------------------
// tkcs_pkg
// Shared types and constants of the top-k cosine vector search core.
// ---------------------------------------------------------------------------
package tkcs_pkg;

  localparam int CAPACITY  = 256;
  localparam int CAP_W     = 8;
  localparam int CNT_W     = 9;
  localparam int DIM_MAX   = 64;
  localparam int DIM_W     = 6;
  localparam int LEN_W     = 7;
  localparam int LIM_W     = 5;
  localparam int TOP_MAX   = 16;
  localparam int TOP_W     = 4;
  localparam int ELEM_W    = 16;
  localparam int ID_W      = 64;
  localparam int NORM_W    = 37;
  localparam int DOT_W     = 38;
  localparam int MAG_W     = 37;
  localparam int PROD_W    = 74;
  localparam int DIV_W     = 104;
  localparam int QUO_W     = 30;
  localparam int ROOT_W    = 14;
  localparam int SCORE_W   = 16;
  localparam int VADDR_W   = CAP_W + DIM_W;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_W     = 7;

  localparam logic [SCORE_W-1:0] SCORE_ONE   = 16'h4000;
  localparam logic [SCORE_W-1:0] EMPTY_SCORE = 16'hC000;

  localparam logic CFG_VLEN = 1'b0;
  localparam logic CFG_RLIM = 1'b1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_DOT,
    S_SCORE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_MUL,
    SP_DIV,
    SP_ROOT
  } sphase_t;

  typedef struct packed {
    logic clear;
    logic ins;
  } topk_ctl_t;

endpackage

>>> hw/rtl/tkcs_ram.sv
// ---------------------------------------------------------------------------
// tkcs_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module tkcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/tkcs_score.sv
// ---------------------------------------------------------------------------
// tkcs_score
// Iterative cosine score: serial shift-add multiplies, restoring divide, bitwise root.
// ---------------------------------------------------------------------------
module tkcs_score (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [tkcs_pkg::DOT_W-1:0]    dot,
  input  logic [tkcs_pkg::NORM_W-1:0]          qnorm,
  input  logic [tkcs_pkg::NORM_W-1:0]          vnorm,
  output logic                                 done,
  output logic signed [tkcs_pkg::SCORE_W-1:0]  score
);
  import tkcs_pkg::*;

  sphase_t phase_r, phase_nxt;

  logic [5:0]            cnt_r;
  logic                  neg_r;
  logic [PROD_W-1:0]     m1a_r, m2a_r, p1_r, p2_r, p1_add, p2_add;
  logic [MAG_W-1:0]      m1b_r;
  logic [NORM_W-1:0]     m2b_r;
  logic [DIV_W-1:0]      rem_r, div_r;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [ROOT_W-1:0]     root_r, bit_r, t;
  logic [2*ROOT_W-1:0]   tsq;
  logic                  ge, fits, sat, zero_in;
  logic [DOT_W-1:0]      dot_abs;
  logic [ROOT_W-1:0]     root_fin;
  logic [SCORE_W-1:0]    sval;
  logic                  done_r;
  logic [SCORE_W-1:0]    score_r;

  always_comb begin
    dot_abs  = dot[DOT_W-1] ? (-dot) : dot;
    zero_in  = (qnorm == '0) || (vnorm == '0);
    p1_add   = p1_r + (m1b_r[0] ? m1a_r : '0);
    p2_add   = p2_r + (m2b_r[0] ? m2a_r : '0);
    ge       = rem_r >= div_r;
    quo_nxt  = {quo_r[QUO_W-2:0], ge};
    sat      = quo_nxt[QUO_W-1] | quo_nxt[QUO_W-2];
    t        = root_r | bit_r;
    tsq      = t * t;
    fits     = tsq <= quo_r[2*ROOT_W-1:0];
    root_fin = fits ? t : root_r;
    sval     = SCORE_W'(root_fin);
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      SP_IDLE: if (start && !zero_in) phase_nxt = SP_MUL;
      SP_MUL:  if (cnt_r == 6'(MAG_W - 1)) phase_nxt = SP_DIV;
      SP_DIV: begin
        if (cnt_r == 6'(QUO_W - 1)) phase_nxt = sat ? SP_IDLE : SP_ROOT;
      end
      SP_ROOT: if (bit_r[0]) phase_nxt = SP_IDLE;
      default: phase_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= ((phase_r == SP_IDLE) && start && zero_in) ||
                 ((phase_r == SP_DIV) && (cnt_r == 6'(QUO_W - 1)) && sat) ||
                 ((phase_r == SP_ROOT) && bit_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase_r)
      SP_IDLE: begin
        if (start) begin
          neg_r   <= dot[DOT_W-1];
          m1a_r   <= PROD_W'(dot_abs[MAG_W-1:0]);
          m1b_r   <= dot_abs[MAG_W-1:0];
          m2a_r   <= PROD_W'(qnorm);
          m2b_r   <= vnorm;
          p1_r    <= '0;
          p2_r    <= '0;
          cnt_r   <= '0;
          score_r <= '0;
        end
      end
      SP_MUL: begin
        p1_r  <= p1_add;
        p2_r  <= p2_add;
        m1a_r <= m1a_r << 1;
        m2a_r <= m2a_r << 1;
        m1b_r <= m1b_r >> 1;
        m2b_r <= m2b_r >> 1;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(MAG_W - 1)) begin
          rem_r <= DIV_W'(p1_add) << (2 * ROOT_W);
          div_r <= DIV_W'(p2_add) << (QUO_W - 1);
          quo_r <= '0;
          cnt_r <= '0;
        end
      end
      SP_DIV: begin
        if (ge) rem_r <= rem_r - div_r;
        div_r <= div_r >> 1;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 6'd1;
        root_r <= '0;
        bit_r  <= ROOT_W'(1) << (ROOT_W - 1);
        if (sat) score_r <= neg_r ? (-SCORE_ONE) : SCORE_ONE;
      end
      SP_ROOT: begin
        root_r  <= root_fin;
        bit_r   <= bit_r >> 1;
        score_r <= neg_r ? (-sval) : sval;
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign score = score_r;

endmodule

>>> hw/rtl/tkcs_topk.sv
// ---------------------------------------------------------------------------
// tkcs_topk
// Best-first list of scores and ids with strict-greater insertion.
// ---------------------------------------------------------------------------
module tkcs_topk (
  input  logic                                clk,
  input  tkcs_pkg::topk_ctl_t                 ctl,
  input  logic [tkcs_pkg::LIM_W-1:0]          lim,
  input  logic signed [tkcs_pkg::SCORE_W-1:0] score,
  input  logic [tkcs_pkg::ID_W-1:0]           id,
  input  logic [tkcs_pkg::TOP_W-1:0]          rank,
  output logic [tkcs_pkg::SCORE_W-1:0]        rd_score,
  output logic [tkcs_pkg::ID_W-1:0]           rd_id
);
  import tkcs_pkg::*;

  logic signed [SCORE_W-1:0] best_s_r  [TOP_MAX];
  logic [ID_W-1:0]           best_id_r [TOP_MAX];
  logic [TOP_MAX-1:0]        gt;

  always_comb begin
    for (int j = 0; j < TOP_MAX; j++) begin
      gt[j] = (LIM_W'(j) < lim) && (score > best_s_r[j]);
    end
  end

  for (genvar gi = 0; gi < TOP_MAX; gi++) begin : g_slot
    always_ff @(posedge clk) begin
      if (ctl.clear) begin
        best_s_r[gi]  <= EMPTY_SCORE;
        best_id_r[gi] <= '0;
      end else if (ctl.ins && gt[gi]) begin
        if (gi == 0) begin
          best_s_r[gi]  <= score;
          best_id_r[gi] <= id;
        end else if (!gt[(gi == 0) ? 0 : gi - 1]) begin
          best_s_r[gi]  <= score;
          best_id_r[gi] <= id;
        end else begin
          best_s_r[gi]  <= best_s_r[(gi == 0) ? 0 : gi - 1];
          best_id_r[gi] <= best_id_r[(gi == 0) ? 0 : gi - 1];
        end
      end
    end
  end

  assign rd_score = best_s_r[rank];
  assign rd_id    = best_id_r[rank];

endmodule

>>> hw/rtl/top_k_cosine_vector_search_core.sv
// ---------------------------------------------------------------------------
// top_k_cosine_vector_search_core
// Vector store with brute-force top-k cosine search over RAM-held vectors.
// ---------------------------------------------------------------------------
// Elements: one per cycle unless a result is held; insert and query answer only
// the last element, a clear answers each. Insert done: result next cycle; a
// valid insert also runs the norm pass. Query done: per stored entry, MAC reads
// then the score unit (37 multiply, 30 divide, up to 14 root steps); then one
// result per cycle while out_tready is high. Input stalls during both passes.
// Reset (rst_n low, synchronous) empties the store; vector RAMs are not cleared.
module top_k_cosine_vector_search_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // element_value [15:0], entry_id [79:16]
  input  logic [tkcs_pkg::IN_DATA_W-1:0]     in_tdata,
  // command [1:0]
  input  logic [1:0]                         in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // result_id [63:0], result_score [79:64], result_rank [83:80], zero pad
  output logic [tkcs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status [1:0]
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [tkcs_pkg::CFG_W-1:0]         cfg_wdata
);
  import tkcs_pkg::*;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  vlen_r;
  logic [LIM_W-1:0]  rlim_r, lim_r, out_cnt_r;
  logic [CNT_W-1:0]  ecount_r, idx_r;
  logic [LEN_W-1:0]  ecnt_r, iss_r;
  logic [NORM_W-1:0] qsum_r, qnorm_r;
  logic [ID_W-1:0]   id_r;
  logic              rd_v_r, pr_v_r;
  logic signed [2*ELEM_W-1:0] prod_r;
  logic signed [DOT_W-1:0]    acc_r;

  logic              out_valid_r, out_last_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [TOP_W-1:0]  out_rank_r;

  cmd_t                      cmd;
  logic signed [ELEM_W-1:0]  elem;
  logic [ID_W-1:0]           in_id;
  logic                      accept, out_free, pos_ok, len_ok, issuing, pipe_done;
  logic [LEN_W-1:0]          ecnt_inc;
  logic signed [2*ELEM_W-1:0] sq;
  logic [NORM_W-1:0]         qsum_nxt;
  logic [LIM_W-1:0]          lim_sat;

  logic                  v_we, q_we, iv_we;
  logic [VADDR_W-1:0]    v_addr;
  logic [DIM_W-1:0]      q_addr;
  logic [CAP_W-1:0]      iv_addr;
  logic [ELEM_W-1:0]     v_rdata, q_rdata;
  logic [ID_W-1:0]       id_rdata;
  logic [NORM_W-1:0]     n_rdata;
  logic signed [ELEM_W-1:0] op_a, op_b;

  logic                  sc_start, sc_done;
  logic signed [SCORE_W-1:0] sc_score;
  topk_ctl_t             tk_ctl;
  logic [SCORE_W-1:0]    tk_score;
  logic [ID_W-1:0]       tk_id;

  logic                  res_load, q_start, ins_norm, out_step, out_end;
  status_t               res_status;

  assign cmd     = cmd_t'(in_tuser);
  assign elem    = signed'(in_tdata[ELEM_W-1:0]);
  assign in_id   = in_tdata[ELEM_W+ID_W-1:ELEM_W];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept  = in_tvalid && in_tready;

  always_comb begin
    pos_ok   = ecnt_r < LEN_W'(DIM_MAX);
    ecnt_inc = (ecnt_r < LEN_W'(DIM_MAX + 1)) ? (ecnt_r + 1'b1) : ecnt_r;
    len_ok   = (vlen_r != '0) && (vlen_r <= LEN_W'(DIM_MAX)) && (ecnt_inc == vlen_r);
    sq       = elem * elem;
    qsum_nxt = (cmd == CMD_QUERY && pos_ok) ?
               (qsum_r + NORM_W'(unsigned'(sq))) : qsum_r;
    lim_sat  = (rlim_r > LIM_W'(TOP_MAX)) ? LIM_W'(TOP_MAX) : rlim_r;
    issuing  = ((state_r == S_NORM) || (state_r == S_DOT)) && (iss_r < vlen_r);
    pipe_done = (iss_r == vlen_r) && !rd_v_r && !pr_v_r;
    op_b     = signed'(v_rdata);
    op_a     = (state_r == S_NORM) ? signed'(v_rdata) : signed'(q_rdata);
    out_end  = LIM_W'(out_cnt_r + 1'b1) == lim_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_tlast) begin
          if (cmd == CMD_INSERT && len_ok && ecount_r < CNT_W'(CAPACITY)) begin
            state_nxt = S_NORM;
          end else if (cmd == CMD_QUERY && len_ok && rlim_r != '0) begin
            state_nxt = (ecount_r == '0) ? S_OUT : S_DOT;
          end
        end
      end
      S_NORM:  if (pipe_done) state_nxt = S_IDLE;
      S_DOT:   if (pipe_done) state_nxt = S_SCORE;
      S_SCORE: begin
        if (sc_done) state_nxt = (CNT_W'(idx_r + 1'b1) == ecount_r) ? S_OUT : S_DOT;
      end
      S_OUT:   if (out_free && out_end) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    v_we       = 1'b0;
    q_we       = 1'b0;
    iv_we      = 1'b0;
    v_addr     = {idx_r[CAP_W-1:0], iss_r[DIM_W-1:0]};
    q_addr     = iss_r[DIM_W-1:0];
    iv_addr    = idx_r[CAP_W-1:0];
    sc_start   = 1'b0;
    tk_ctl     = '0;
    res_load   = 1'b0;
    res_status = ST_OK;
    q_start    = 1'b0;
    ins_norm   = 1'b0;
    out_step   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        v_addr = {ecount_r[CAP_W-1:0], ecnt_r[DIM_W-1:0]};
        q_addr = ecnt_r[DIM_W-1:0];
        if (accept) begin
          v_we = (cmd == CMD_INSERT) && pos_ok && (ecount_r < CNT_W'(CAPACITY));
          q_we = (cmd == CMD_QUERY) && pos_ok;
          if (cmd == CMD_CLEAR) begin
            res_load = 1'b1;
          end else if (in_tlast && cmd == CMD_INSERT) begin
            res_load = 1'b1;
            if (!len_ok) res_status = ST_BAD_LEN;
            else if (ecount_r >= CNT_W'(CAPACITY)) res_status = ST_FULL;
            else ins_norm = 1'b1;
          end else if (in_tlast && cmd == CMD_QUERY) begin
            if (!len_ok || rlim_r == '0) begin
              res_load   = 1'b1;
              res_status = ST_BAD_LEN;
            end else begin
              q_start    = 1'b1;
              tk_ctl.clear = 1'b1;
            end
          end
        end
      end
      S_NORM: begin
        v_addr  = {ecount_r[CAP_W-1:0], iss_r[DIM_W-1:0]};
        iv_addr = ecount_r[CAP_W-1:0];
        iv_we   = pipe_done;
      end
      S_DOT:   sc_start = pipe_done;
      S_SCORE: tk_ctl.ins = sc_done;
      S_OUT:   out_step = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vlen_r      <= LEN_W'(DIM_MAX);
      rlim_r      <= LIM_W'(1);
      ecount_r    <= '0;
      ecnt_r      <= '0;
      qsum_r      <= '0;
      rd_v_r      <= 1'b0;
      pr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VLEN: vlen_r <= cfg_wdata[LEN_W-1:0];
          CFG_RLIM: rlim_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (cmd == CMD_CLEAR) begin
          ecount_r <= '0;
          ecnt_r   <= '0;
          qsum_r   <= '0;
        end else if (cmd == CMD_INSERT || cmd == CMD_QUERY) begin
          ecnt_r <= in_tlast ? '0 : ecnt_inc;
          qsum_r <= in_tlast ? '0 : qsum_nxt;
        end
      end
      if (iv_we) ecount_r <= ecount_r + 1'b1;
      rd_v_r <= issuing;
      pr_v_r <= rd_v_r;
      if (res_load || out_step) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_norm) id_r <= in_id;
    if (q_start) begin
      qnorm_r <= qsum_nxt;
      lim_r   <= lim_sat;
      idx_r   <= '0;
      out_cnt_r <= '0;
    end
    if (ins_norm || q_start || (state_r == S_SCORE && sc_done)) begin
      iss_r <= '0;
      acc_r <= '0;
    end else begin
      if (issuing) iss_r <= iss_r + 1'b1;
      if (pr_v_r) acc_r <= acc_r + DOT_W'(prod_r);
    end
    if (rd_v_r) prod_r <= op_a * op_b;
    if (state_r == S_SCORE && sc_done) idx_r <= idx_r + 1'b1;
    if (res_load) begin
      out_status_r <= res_status;
      out_id_r     <= '0;
      out_score_r  <= '0;
      out_rank_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (out_step) begin
      out_status_r <= ST_OK;
      out_id_r     <= tk_id;
      out_score_r  <= tk_score;
      out_rank_r   <= out_cnt_r[TOP_W-1:0];
      out_last_r   <= out_end;
      out_cnt_r    <= out_cnt_r + 1'b1;
    end
  end

  tkcs_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY * DIM_MAX)) u_vec_ram (
    .clk   (clk),
    .we    (v_we),
    .addr  (v_addr),
    .wdata (in_tdata[ELEM_W-1:0]),
    .rdata (v_rdata)
  );

  tkcs_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .addr  (q_addr),
    .wdata (in_tdata[ELEM_W-1:0]),
    .rdata (q_rdata)
  );

  tkcs_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_ram (
    .clk   (clk),
    .we    (iv_we),
    .addr  (iv_addr),
    .wdata (id_r),
    .rdata (id_rdata)
  );

  tkcs_ram #(.WIDTH(NORM_W), .DEPTH(CAPACITY)) u_norm_ram (
    .clk   (clk),
    .we    (iv_we),
    .addr  (iv_addr),
    .wdata (acc_r[NORM_W-1:0]),
    .rdata (n_rdata)
  );

  tkcs_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .dot   (acc_r),
    .qnorm (qnorm_r),
    .vnorm (n_rdata),
    .done  (sc_done),
    .score (sc_score)
  );

  tkcs_topk u_topk (
    .clk      (clk),
    .ctl      (tk_ctl),
    .lim      (q_start ? lim_sat : lim_r),
    .score    (sc_score),
    .id       (id_rdata),
    .rank     (out_cnt_r[TOP_W-1:0]),
    .rd_score (tk_score),
    .rd_id    (tk_id)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_W - SCORE_W - TOP_W){1'b0}},
                       out_rank_r, out_score_r, out_id_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
